FILE: hdl/alu8f_pkg.sv
// ----------------------------------------------------------------------------
// alu8f_pkg: shared types and constants for the 8-bit arithmetic ALU
// Operation codes, flag bit positions and the request/response beat formats.
// ----------------------------------------------------------------------------
package alu8f_pkg;

   // Operation codes; codes ten to fifteen are a no-op
   localparam logic [3:0] OP_ADD = 4'd0;
   localparam logic [3:0] OP_ADC = 4'd1;
   localparam logic [3:0] OP_SUB = 4'd2;
   localparam logic [3:0] OP_SBB = 4'd3;
   localparam logic [3:0] OP_INR = 4'd4;
   localparam logic [3:0] OP_DCR = 4'd5;
   localparam logic [3:0] OP_INX = 4'd6;
   localparam logic [3:0] OP_DCX = 4'd7;
   localparam logic [3:0] OP_DAD = 4'd8;
   localparam logic [3:0] OP_DAA = 4'd9;

   // Flag bit positions
   localparam int FLAG_S = 4;
   localparam int FLAG_Z = 3;
   localparam int FLAG_H = 2;
   localparam int FLAG_P = 1;
   localparam int FLAG_C = 0;

   // Decimal adjust constants
   localparam logic [3:0] BCD_MAX_DIGIT = 4'd9;
   localparam logic [7:0] BCD_ADJ_LO    = 8'h06;
   localparam logic [7:0] BCD_ADJ_HI    = 8'h60;

   typedef struct packed {
      logic [3:0]  operation;
      logic [7:0]  acc_in;
      logic [4:0]  flags_in;
      logic [7:0]  operand;
      logic [15:0] pair_value;
      logic [15:0] hl_value;
   } req_type;

   typedef struct packed {
      logic [7:0]  acc_out;
      logic [7:0]  byte_out;
      logic [15:0] pair_out;
      logic [4:0]  flags_out;
   } rsp_type;

endpackage

FILE: hdl/eight_bit_arith_alu_with_flags.sv
// ----------------------------------------------------------------------------
// eight_bit_arith_alu_with_flags: 8080-style arithmetic unit with flags
// Two-register pipeline: request register, one pass of ALU logic, response
// register.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req_data) carries one operation with
//   its accumulator, flags, byte operand, register pair and HL. Response
//   channel (rsp_valid/rsp_ready/rsp_data) returns the new accumulator, the
//   INR/DCR byte, the 16-bit pair result and the new flags, one beat per
//   request, in order.
//   A request beat is held in the request register, passes the ALU logic and
//   is registered in the response register, which drives rsp_valid.
//   Throughput is one beat per cycle while rsp_ready stays high, set by the
//   single ALU pass between the two registers.
//   When the receiver stalls, the response register holds and the request
//   register fills; req_ready drops only once both are occupied and rsp_ready
//   is low, and each stage advances as soon as the stage after it frees up.
//   Reset clears both valid bits; the data registers are not reset, no config.
// ----------------------------------------------------------------------------
module eight_bit_arith_alu_with_flags (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  alu8f_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output alu8f_pkg::rsp_type  rsp_data
);

   logic               in_vld_ff, in_vld_in;
   alu8f_pkg::req_type in_ff;
   logic               out_vld_ff, out_vld_in;
   alu8f_pkg::rsp_type out_ff;
   logic               out_open;
   logic               in_open;
   logic               in_move;
   alu8f_pkg::rsp_type res;

   // Adder datapath
   logic [7:0] add_a;
   logic [7:0] add_b;
   logic       add_cin;
   logic [8:0] add_sum;
   logic [4:0] add_half;
   logic [4:0] add_flags;

   // Decimal adjust datapath
   logic [3:0] daa_lo;
   logic [3:0] daa_hi;
   logic       daa_lo_adj;
   logic       daa_hi_adj;
   logic [7:0] daa_corr;
   logic [7:0] daa_acc;
   logic [4:0] daa_half;

   // Pair datapath
   logic [16:0] dad_sum;
   logic [15:0] inx_val;
   logic [15:0] dcx_val;

   logic cy;

   // Handshake: each stage takes a beat when it is empty or draining
   assign out_open  = !out_vld_ff || rsp_ready;
   assign in_open   = !in_vld_ff || out_open;
   assign in_move   = in_vld_ff && out_open;
   assign req_ready = in_open;

   assign in_vld_in  = (req_valid && in_open) ? 1'b1 : (in_move ? 1'b0 : in_vld_ff);
   assign out_vld_in = in_move ? 1'b1 : (rsp_ready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Load the request register on an accepted beat
   always_ff @(posedge clock) begin
      if (req_valid && in_open) begin
         in_ff <= req_data;
      end
   end

   // Advance the ALU result into the response register
   always_ff @(posedge clock) begin
      if (in_move) begin
         out_ff <= res;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   assign cy = in_ff.flags_in[alu8f_pkg::FLAG_C];

   // Select adder operands; subtraction adds the complement
   always_comb begin
      add_a   = in_ff.acc_in;
      add_b   = in_ff.operand;
      add_cin = 1'b0;
      case (in_ff.operation)
         alu8f_pkg::OP_ADC: begin
            add_cin = cy;
         end
         alu8f_pkg::OP_SUB: begin
            add_b   = ~in_ff.operand;
            add_cin = 1'b1;
         end
         alu8f_pkg::OP_SBB: begin
            add_b   = ~in_ff.operand;
            add_cin = ~cy;
         end
         alu8f_pkg::OP_INR: begin
            add_a = in_ff.operand;
            add_b = 8'h01;
         end
         alu8f_pkg::OP_DCR: begin
            add_a   = in_ff.operand;
            add_b   = 8'hFE;
            add_cin = 1'b1;
         end
         default: begin
            add_cin = 1'b0;
         end
      endcase
   end

   assign add_sum  = {1'b0, add_a} + {1'b0, add_b} + {8'd0, add_cin};
   assign add_half = {1'b0, add_a[3:0]} + {1'b0, add_b[3:0]} + {4'd0, add_cin};

   assign add_flags[alu8f_pkg::FLAG_S] = add_sum[7];
   assign add_flags[alu8f_pkg::FLAG_Z] = (add_sum[7:0] == 8'd0);
   assign add_flags[alu8f_pkg::FLAG_H] = add_half[4];
   assign add_flags[alu8f_pkg::FLAG_P] = ~^add_sum[7:0];
   assign add_flags[alu8f_pkg::FLAG_C] = add_sum[8];

   // Decimal adjust of the accumulator
   assign daa_lo     = in_ff.acc_in[3:0];
   assign daa_hi     = in_ff.acc_in[7:4];
   assign daa_lo_adj = (daa_lo > alu8f_pkg::BCD_MAX_DIGIT) ||
                       in_ff.flags_in[alu8f_pkg::FLAG_H];
   assign daa_hi_adj = (daa_hi > alu8f_pkg::BCD_MAX_DIGIT) ||
                       ((daa_hi >= alu8f_pkg::BCD_MAX_DIGIT) &&
                        (daa_lo > alu8f_pkg::BCD_MAX_DIGIT)) || cy;
   assign daa_corr   = (daa_lo_adj ? alu8f_pkg::BCD_ADJ_LO : 8'h00) |
                       (daa_hi_adj ? alu8f_pkg::BCD_ADJ_HI : 8'h00);
   assign daa_acc    = in_ff.acc_in + daa_corr;
   assign daa_half   = {1'b0, daa_lo} + {1'b0, daa_corr[3:0]};

   // Pair arithmetic
   assign dad_sum = {1'b0, in_ff.pair_value} + {1'b0, in_ff.hl_value};
   assign inx_val = in_ff.pair_value + 16'd1;
   assign dcx_val = in_ff.pair_value - 16'd1;

   // Build the result beat; untouched flags pass through
   always_comb begin
      res.acc_out   = in_ff.acc_in;
      res.byte_out  = 8'd0;
      res.pair_out  = 16'd0;
      res.flags_out = in_ff.flags_in;
      unique case (in_ff.operation)
         alu8f_pkg::OP_ADD, alu8f_pkg::OP_ADC: begin
            res.acc_out   = add_sum[7:0];
            res.flags_out = add_flags;
         end
         alu8f_pkg::OP_SUB, alu8f_pkg::OP_SBB: begin
            res.acc_out   = add_sum[7:0];
            res.flags_out = add_flags;
            res.flags_out[alu8f_pkg::FLAG_C] = ~add_sum[8];
         end
         alu8f_pkg::OP_INR, alu8f_pkg::OP_DCR: begin
            res.byte_out  = add_sum[7:0];
            res.flags_out = add_flags;
            res.flags_out[alu8f_pkg::FLAG_C] = cy;
         end
         alu8f_pkg::OP_INX: begin
            res.pair_out = inx_val;
         end
         alu8f_pkg::OP_DCX: begin
            res.pair_out = dcx_val;
         end
         alu8f_pkg::OP_DAD: begin
            res.pair_out = dad_sum[15:0];
            res.flags_out[alu8f_pkg::FLAG_C] = dad_sum[16];
         end
         alu8f_pkg::OP_DAA: begin
            res.acc_out = daa_acc;
            res.flags_out[alu8f_pkg::FLAG_S] = daa_acc[7];
            res.flags_out[alu8f_pkg::FLAG_Z] = (daa_acc == 8'd0);
            res.flags_out[alu8f_pkg::FLAG_H] = daa_half[4];
            res.flags_out[alu8f_pkg::FLAG_P] = ~^daa_acc;
            res.flags_out[alu8f_pkg::FLAG_C] = daa_hi_adj | cy;
         end
         default: begin
            res.acc_out = in_ff.acc_in;
         end
      endcase
   end

   // A held request moves to the response stage once it is free
   a_advance: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && out_open |=> out_vld_ff)
      else $error("request beat did not advance to response stage");

   // Request side never stalls while the pipeline is empty
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff && !out_vld_ff |-> req_ready)
      else $error("req_ready low with empty pipeline");

   // Byte result is zero except for INR and DCR
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && in_ff.operation != alu8f_pkg::OP_INR &&
      in_ff.operation != alu8f_pkg::OP_DCR |-> res.byte_out == 8'd0)
      else $error("byte result set for non-INR/DCR operation");

   // Full pipeline under stall stays full
   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && out_vld_ff && !rsp_ready |=> in_vld_ff && out_vld_ff)
      else $error("beat dropped while receiver stalled");

endmodule
